### design/rat_pkg.sv
// Package for the range alias translation table.
// Holds the window entry type, compare result type and command codes.
// No dependencies.
package rat_pkg;

  localparam int ADDR_W  = 64;
  localparam int OFS_W   = 28;
  localparam int SIZE_W  = 29;
  localparam int CMD_W   = 2;
  localparam int OCNT_W  = 7;   // count fields on the result word

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              contains;  // key address falls inside the window
    logic              match;     // exact destination and size match
    logic [ADDR_W-1:0] rel;       // key address minus destination
  } cmp_res_t;

endpackage

### design/rat_cmp.sv
// Shared compare unit: one 64-bit subtract checked against window bounds.
// Depends on rat_pkg.
module rat_cmp (
  input  logic [rat_pkg::ADDR_W-1:0] key_addr,
  input  logic [rat_pkg::SIZE_W-1:0] key_size,
  input  rat_pkg::entry_t            ent,
  output rat_pkg::cmp_res_t          res
);
  import rat_pkg::*;

  logic [ADDR_W:0] diff;   // top bit is the borrow

  assign diff = {1'b0, key_addr} - {1'b0, ent.dest};

  always_comb begin
    res.rel      = diff[ADDR_W-1:0];
    res.contains = !diff[ADDR_W]
                   && (diff[ADDR_W-1:SIZE_W] == '0)
                   && (diff[SIZE_W-1:0] < ent.size);
    res.match    = (diff == '0) && (ent.size == key_size);
  end

endmodule

### design/rat_mem.sv
// Window store: one write port, two registered read ports.
// Depends on rat_pkg.
module rat_mem #(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  rat_pkg::entry_t      wr_data,
  input  logic [IDX_W-1:0]     rd_addr_a,
  input  logic                 rd_en_b,
  input  logic [IDX_W-1:0]     rd_addr_b,
  output rat_pkg::entry_t      rd_a,
  output rat_pkg::entry_t      rd_b
);
  import rat_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_a_r;
  entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= mem[rd_addr_a];
    if (rd_en_b) begin
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

### design/range_alias_translation_table_unit.sv
// Top level of the range alias translation table: sequencer, count and
// result registers. Depends on rat_pkg, rat_cmp and rat_mem.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  input    | start / busy      | in_command, in_address, in_offset,
//           |                   | in_window_size
//  result   | out_valid strobe  | out_found, out_translated, out_stored,
//           |                   | out_removed_count, out_entries_in_use
//  config   | cfg_wr_en         | cfg_wr_data (code base)
//
// Insert and clear: result in the cycle after the word is taken.
// Lookup: one entry per cycle through the shared compare unit, the hit's
//   add done in a state of its own.
// Remove: each removal refills its slot from the last entry, read on the
//   second memory port, and tests it again; the scan then ends one slot
//   sooner.
// Reset (synchronous, rst_n low) empties the table and clears code base;
//   no clearing pass, unwritten slots are never read.
// The receiver cannot stall: out_valid is high for exactly one cycle.
module range_alias_translation_table_unit #(
  parameter int ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [rat_pkg::CMD_W-1:0]  in_command,
  input  logic [rat_pkg::ADDR_W-1:0] in_address,
  input  logic [rat_pkg::OFS_W-1:0]  in_offset,
  input  logic [rat_pkg::SIZE_W-1:0] in_window_size,
  output logic                       out_valid,
  output logic                       out_found,
  output logic [rat_pkg::ADDR_W-1:0] out_translated,
  output logic                       out_stored,
  output logic [rat_pkg::OCNT_W-1:0] out_removed_count,
  output logic [rat_pkg::OCNT_W-1:0] out_entries_in_use,
  input  logic                       cfg_wr_en,
  input  logic [rat_pkg::ADDR_W-1:0] cfg_wr_data
);
  import rat_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;   // walk entries, one per cycle, held while a remove refills a slot
  localparam logic [1:0] ST_ADD  = 2'd2;   // lookup hit: source + rel

  // control
  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  rm_r, rm_nxt;
  logic              cur_sel_r, cur_sel_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] code_base_r;

  // payload
  logic [CMD_W-1:0]  cmd_r;
  logic [ADDR_W-1:0] key_addr_r;
  logic [SIZE_W-1:0] key_size_r;
  entry_t            cur_r, cur_nxt;
  logic [ADDR_W-1:0] rel_r, rel_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] trans_r, trans_nxt;
  logic              stored_r, stored_nxt;
  logic [OCNT_W-1:0] orm_r, orm_nxt;
  logic [OCNT_W-1:0] ouse_r, ouse_nxt;

  logic              accept;
  logic [CNT_W-1:0]  idx_p1, cnt_m1, cnt_m2;
  logic              scan_end;
  entry_t            rd_a, rd_b, operand, wr_data;
  cmp_res_t          cres;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;
  logic              rd_en_b;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign idx_p1   = idx_r + 1'b1;
  assign cnt_m1   = cnt_r - 1'b1;
  assign cnt_m2   = cnt_r - 2'd2;
  assign scan_end = (idx_r >= cnt_r);
  assign operand  = cur_sel_r ? cur_r : rd_a;

  rat_cmp u_cmp (
    .key_addr (key_addr_r),
    .key_size (key_size_r),
    .ent      (operand),
    .res      (cres)
  );

  rat_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_en_b   (rd_en_b),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    rm_nxt        = rm_r;
    cur_sel_nxt   = cur_sel_r;
    cur_nxt       = cur_r;
    rel_nxt       = rel_r;
    src_nxt       = src_r;
    out_valid_nxt = 1'b0;
    found_nxt     = found_r;
    trans_nxt     = trans_r;
    stored_nxt    = stored_r;
    orm_nxt       = orm_r;
    ouse_nxt      = ouse_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[IDX_W-1:0];
    wr_data.dest  = in_address;
    wr_data.src   = code_base_r + ADDR_W'(in_offset);
    wr_data.size  = in_window_size;
    rd_addr_a     = idx_p1[IDX_W-1:0];
    rd_addr_b     = cnt_m2[IDX_W-1:0];
    rd_en_b       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // prime both read ports: slot 0 and the last slot
        rd_addr_a = '0;
        rd_addr_b = cnt_m1[IDX_W-1:0];
        if (start) begin
          idx_nxt     = '0;
          rm_nxt      = '0;
          cur_sel_nxt = 1'b0;
          found_nxt   = 1'b0;
          trans_nxt   = '0;
          stored_nxt  = 1'b0;
          orm_nxt     = '0;
          unique case (in_command)
            CMD_LOOKUP: state_nxt = ST_SCAN;
            CMD_REMOVE: begin
              rd_en_b   = 1'b1;
              state_nxt = ST_SCAN;
            end
            CMD_INSERT: begin
              if (cnt_r < FULL) begin
                wr_en      = 1'b1;
                cnt_nxt    = cnt_r + 1'b1;
                stored_nxt = 1'b1;
              end
              ouse_nxt      = OCNT_W'(cnt_nxt);
              out_valid_nxt = 1'b1;
            end
            CMD_CLEAR: begin
              cnt_nxt       = '0;
              ouse_nxt      = '0;
              out_valid_nxt = 1'b1;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_end) begin
          if (cmd_r == CMD_REMOVE) begin
            orm_nxt = OCNT_W'(rm_r);
          end
          ouse_nxt      = OCNT_W'(cnt_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (cmd_r == CMD_REMOVE) begin
          if (cres.match) begin
            // refill this slot from the last entry and test it again
            wr_en       = 1'b1;
            wr_addr     = idx_r[IDX_W-1:0];
            wr_data     = rd_b;
            cnt_nxt     = cnt_m1;
            rm_nxt      = rm_r + 1'b1;
            cur_nxt     = rd_b;
            cur_sel_nxt = 1'b1;
            // new last is this slot itself: port B already holds it
            rd_en_b     = (idx_r != cnt_m2);
          end else begin
            idx_nxt     = idx_p1;
            cur_sel_nxt = 1'b0;
          end
        end else begin
          if (cres.contains) begin
            rel_nxt   = cres.rel;
            src_nxt   = operand.src;
            state_nxt = ST_ADD;
          end else begin
            idx_nxt     = idx_p1;
            cur_sel_nxt = 1'b0;
          end
        end
      end

      ST_ADD: begin
        found_nxt     = 1'b1;
        trans_nxt     = src_r + rel_r;
        ouse_nxt      = OCNT_W'(cnt_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      rm_r        <= '0;
      cur_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
      code_base_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      rm_r        <= rm_nxt;
      cur_sel_r   <= cur_sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        code_base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_command;
      key_addr_r <= in_address;
      key_size_r <= in_window_size;
    end
    cur_r    <= cur_nxt;
    rel_r    <= rel_nxt;
    src_r    <= src_nxt;
    found_r  <= found_nxt;
    trans_r  <= trans_nxt;
    stored_r <= stored_nxt;
    orm_r    <= orm_nxt;
    ouse_r   <= ouse_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = found_r;
  assign out_translated     = trans_r;
  assign out_stored         = stored_r;
  assign out_removed_count  = orm_r;
  assign out_entries_in_use = ouse_r;

  // count never exceeds table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("entry count above depth");

  // scan index never passes the count
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= cnt_r))
    else $error("scan index beyond count");

  // a result word always comes with the sequencer back at idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // insert into a non-full table is stored and reported next cycle
  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_INSERT) && (cnt_r < FULL))
      |=> (out_valid && out_stored && (cnt_r == $past(cnt_r) + 1'b1)))
    else $error("insert not stored");

  // a remove never grows the table
  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (cmd_r == CMD_REMOVE)) |=> (cnt_r <= $past(cnt_r)))
    else $error("remove grew table");

endmodule

### tb/testbench.sv
// Self-checking bench for range_alias_translation_table_unit: directed
// window cases, then randomized insert/lookup/remove/clear phases under
// several code bases. Depends on rat_pkg and the unit under test.
module testbench;
  import rat_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int MAX_GAP     = 12;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 150;
  localparam int DRAIN_CYCLES = 200;
  localparam int POOL_CAP    = 96;

  // One entry of the stimulus queue: either a command word or a code base write.
  typedef struct packed {
    logic              is_cfg;
    logic [ADDR_W-1:0] cfg_value;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [OFS_W-1:0]  ofs;
    logic [SIZE_W-1:0] size;
  } table_word_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] translated;
    logic              stored;
    logic [OCNT_W-1:0] removed;
    logic [OCNT_W-1:0] in_use;
  } table_result_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  in_command = CMD_LOOKUP;
  logic [ADDR_W-1:0] in_address = '0;
  logic [OFS_W-1:0]  in_offset = '0;
  logic [SIZE_W-1:0] in_window_size = '0;
  logic              out_valid;
  logic              out_found;
  logic [ADDR_W-1:0] out_translated;
  logic              out_stored;
  logic [OCNT_W-1:0] out_removed_count;
  logic [OCNT_W-1:0] out_entries_in_use;
  logic              cfg_wr_en = 1'b0;
  logic [ADDR_W-1:0] cfg_wr_data = '0;

  range_alias_translation_table_unit #(.ENTRIES(TABLE_DEPTH)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_address        (in_address),
    .in_offset         (in_offset),
    .in_window_size    (in_window_size),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_translated    (out_translated),
    .out_stored        (out_stored),
    .out_removed_count (out_removed_count),
    .out_entries_in_use(out_entries_in_use),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // Shadow copy of the window table and code base.
  logic [ADDR_W-1:0] win_dest [TABLE_DEPTH];
  logic [ADDR_W-1:0] win_src  [TABLE_DEPTH];
  logic [SIZE_W-1:0] win_size [TABLE_DEPTH];
  int                win_count = 0;
  logic [ADDR_W-1:0] shadow_code_base = '0;

  table_word_t   word_queue[$];    // words not yet driven
  table_result_t results_due[$];   // predicted results, oldest first
  int            err_count = 0;

  // Driver-private state.
  table_word_t cur_word;
  int          gap_left = 0;
  logic        burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Synchronous reset, held low at the start, once.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Applies one accepted word to the shadow table and returns the result it
  // should produce.
  function automatic table_result_t table_step(input table_word_t w);
    table_result_t     r;
    logic [ADDR_W-1:0] rel;
    int                i;
    int                last;
    r = '0;
    case (w.cmd)
      CMD_LOOKUP: begin
        // First slot in order that holds the address wins; the compare is
        // done on the difference so nothing wraps into a window.
        for (i = 0; i < win_count && !r.found; i++) begin
          if (w.addr >= win_dest[i]) begin
            rel = w.addr - win_dest[i];
            if (rel < ADDR_W'(win_size[i])) begin
              r.found      = 1'b1;
              r.translated = win_src[i] + rel;
            end
          end
        end
      end
      CMD_INSERT: begin
        if (win_count < TABLE_DEPTH) begin
          win_dest[win_count] = w.addr;
          win_src[win_count]  = shadow_code_base + ADDR_W'(w.ofs);
          win_size[win_count] = w.size;
          win_count++;
          r.stored = 1'b1;
        end
      end
      CMD_REMOVE: begin
        // Each hole is refilled from the last slot and re-examined.
        i = 0;
        while (i < win_count) begin
          if (win_dest[i] == w.addr && win_size[i] == w.size) begin
            last        = win_count - 1;
            win_dest[i] = win_dest[last];
            win_src[i]  = win_src[last];
            win_size[i] = win_size[last];
            win_count--;
            r.removed++;
          end else begin
            i++;
          end
        end
      end
      default: begin
        win_count = 0;
      end
    endcase
    r.in_use = OCNT_W'(win_count);
    return r;
  endfunction

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                          input logic [OFS_W-1:0] ofs, input logic [SIZE_W-1:0] size);
    table_word_t w;
    w        = '0;
    w.cmd    = cmd;
    w.addr   = addr;
    w.ofs    = ofs;
    w.size   = size;
    word_queue.push_back(w);
  endtask

  task automatic push_cfg(input logic [ADDR_W-1:0] value);
    table_word_t w;
    w           = '0;
    w.is_cfg    = 1'b1;
    w.cfg_value = value;
    word_queue.push_back(w);
  endtask

  // Driver. A word is taken at an edge with start high and busy low. After a
  // word is taken the next one follows after a random gap or back to back in
  // burst stretches; a word raised while busy just waits.
  // Code base writes go out only once the block is idle and every result
  // has come back.
  always @(posedge clk) begin
    table_word_t w;
    logic        nxt_start;
    logic        nxt_cfg;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg   = 1'b0;
      if (start && !busy) begin
        results_due.push_back(table_step(cur_word));
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (word_queue.size() > 0) begin
          if (word_queue[0].is_cfg) begin
            // out_valid low guarantees the monitor is not popping this edge
            if (results_due.size() == 0 && !busy && !out_valid && !cfg_wr_en) begin
              w                = word_queue.pop_front();
              nxt_cfg          = 1'b1;
              cfg_wr_data      <= w.cfg_value;
              shadow_code_base = w.cfg_value;
            end
          end else begin
            w              = word_queue.pop_front();
            cur_word       = w;
            in_command     <= w.cmd;
            in_address     <= w.addr;
            in_offset      <= w.ofs;
            in_window_size <= w.size;
            nxt_start      = 1'b1;
            gap_left       = burst ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 29) == 0) burst = ~burst;
          end
        end
      end
      start     <= nxt_start;
      cfg_wr_en <= nxt_cfg;
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        report_mismatch("result word with no prediction pending");
      end else begin
        want = results_due.pop_front();
        if (out_found !== want.found)
          report_mismatch($sformatf("found %b, want %b", out_found, want.found));
        if (out_translated !== want.translated)
          report_mismatch($sformatf("translated %h, want %h",
                                    out_translated, want.translated));
        if (out_stored !== want.stored)
          report_mismatch($sformatf("stored %b, want %b", out_stored, want.stored));
        if (out_removed_count !== want.removed)
          report_mismatch($sformatf("removed_count %0d, want %0d",
                                    out_removed_count, want.removed));
        if (out_entries_in_use !== want.in_use)
          report_mismatch($sformatf("entries_in_use %0d, want %0d",
                                    out_entries_in_use, want.in_use));
      end
    end
  end

  // Stimulus: filled up front, then wait for the run to drain.
  initial begin
    logic [ADDR_W-1:0] pool_dest[$];
    logic [SIZE_W-1:0] pool_size[$];
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] cb;
    logic [OFS_W-1:0]  ofs;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] s;
    int                p;
    int                n;
    int                pick;
    int                idx;
    int                w_lookup;
    int                w_insert;
    int                w_remove;

    // Empty table: lookup misses, clear and remove do nothing.
    push_cmd(CMD_LOOKUP, '1, '0, '0);
    push_cmd(CMD_CLEAR, '0, '0, '0);
    push_cmd(CMD_REMOVE, '0, '0, '0);
    // Window at address zero with reset code base.
    push_cmd(CMD_INSERT, '0, '0, 29'd1);
    push_cmd(CMD_LOOKUP, '0, '0, '0);
    push_cmd(CMD_LOOKUP, 64'd1, '0, '0);
    // Source wraps past 2^64.
    push_cfg(64'hFFFF_FFFF_FFFF_F000);
    push_cmd(CMD_INSERT, 64'h1000, '1, 29'h100);
    push_cmd(CMD_LOOKUP, 64'h1000, '0, '0);
    push_cmd(CMD_LOOKUP, 64'h10FF, '0, '0);
    push_cmd(CMD_LOOKUP, 64'h1100, '0, '0);
    push_cmd(CMD_LOOKUP, 64'h0FFF, '0, '0);
    // Zero-size window never hits.
    push_cmd(CMD_INSERT, 64'h2000, 28'h123, '0);
    push_cmd(CMD_LOOKUP, 64'h2000, '0, '0);
    // Oversized window at the top of the space: no wrap into it.
    push_cmd(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 28'h7, '1);
    push_cmd(CMD_LOOKUP, '1, '0, '0);
    push_cmd(CMD_LOOKUP, 64'h10, '0, '0);
    // Duplicates: lowest slot wins, remove takes all of them.
    push_cmd(CMD_INSERT, 64'h1000, 28'h55, 29'h100);
    push_cmd(CMD_INSERT, 64'h1000, 28'h55, 29'h100);
    push_cmd(CMD_LOOKUP, 64'h1080, '0, '0);
    push_cmd(CMD_REMOVE, 64'h1000, '0, 29'h100);
    // Size compared on all 29 bits.
    push_cmd(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FF00, '0, 29'h0FFF_FFFF);
    push_cmd(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FF00, '0, '1);
    push_cmd(CMD_LOOKUP, '1, '0, '0);
    push_cmd(CMD_CLEAR, '0, '0, '0);

    // Random phases. Kind 0 mixed, kind 1 insert heavy (runs the table
    // full), kind 2 lookup/remove heavy (drains it).
    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: cb = '0;
        1: cb = '1;
        2: cb = 64'h8000_0000_0000_0000;
        default: cb = {$urandom, $urandom};
      endcase
      push_cfg(cb);
      case (p % 3)
        0: begin w_lookup = 40; w_insert = 30; w_remove = 27; end
        1: begin w_lookup = 30; w_insert = 65; w_remove = 4;  end
        default: begin w_lookup = 45; w_insert = 15; w_remove = 39; end
      endcase
      for (n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < w_lookup) begin
          if (pool_dest.size() > 0 && $urandom_range(0, 3) != 0) begin
            // aim at a known window, edges included
            idx = $urandom_range(0, pool_dest.size() - 1);
            s   = pool_size[idx];
            case ($urandom_range(0, 3))
              0: addr = pool_dest[idx];
              1: addr = pool_dest[idx] + ADDR_W'(s) - ((s != 0) ? 64'd1 : 64'd0);
              2: addr = pool_dest[idx] + ADDR_W'(s);
              default: addr = pool_dest[idx] + ((s != 0) ? ADDR_W'($urandom % s) : 64'd0);
            endcase
          end else if ($urandom_range(0, 1) == 0) begin
            addr = {44'h0, 20'($urandom)};
          end else begin
            addr = {$urandom, $urandom};
          end
          push_cmd(CMD_LOOKUP, addr, OFS_W'($urandom), SIZE_W'($urandom));
        end else if (pick < w_lookup + w_insert) begin
          case ($urandom_range(0, 3))
            0: size = SIZE_W'($urandom);
            1: size = ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: size = SIZE_W'($urandom_range(0, 4096));
          endcase
          case ($urandom_range(0, 9))
            0, 1: begin
              if (pool_dest.size() > 0) begin
                idx  = $urandom_range(0, pool_dest.size() - 1);
                addr = pool_dest[idx];
                size = pool_size[idx];
              end else begin
                addr = {44'h0, 20'($urandom)};
              end
            end
            2, 3, 4, 5: addr = {44'h0, 20'($urandom)};
            6: addr = {44'hFFF_FFFF_FFFF, 20'($urandom)};
            default: addr = {$urandom, $urandom};
          endcase
          case ($urandom_range(0, 7))
            0: ofs = '0;
            1: ofs = '1;
            default: ofs = OFS_W'($urandom);
          endcase
          push_cmd(CMD_INSERT, addr, ofs, size);
          pool_dest.push_back(addr);
          pool_size.push_back(size);
          if (pool_dest.size() > POOL_CAP) begin
            void'(pool_dest.pop_front());
            void'(pool_size.pop_front());
          end
        end else if (pick < w_lookup + w_insert + w_remove) begin
          if (pool_dest.size() > 0 && $urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, pool_dest.size() - 1);
            push_cmd(CMD_REMOVE, pool_dest[idx], OFS_W'($urandom), pool_size[idx]);
            pool_dest.delete(idx);
            pool_size.delete(idx);
          end else if (pool_dest.size() > 0 && $urandom_range(0, 1) == 0) begin
            // right base, size off by one bit
            idx = $urandom_range(0, pool_dest.size() - 1);
            push_cmd(CMD_REMOVE, pool_dest[idx], '0,
                     pool_size[idx] ^ (SIZE_W'(1) << $urandom_range(0, SIZE_W - 1)));
          end else begin
            push_cmd(CMD_REMOVE, {$urandom, $urandom}, '0, SIZE_W'($urandom));
          end
        end else begin
          push_cmd(CMD_CLEAR, {$urandom, $urandom}, OFS_W'($urandom), SIZE_W'($urandom));
          pool_dest.delete();
          pool_size.delete();
        end
      end
    end

    // Drain: everything driven, taken and answered, then let the block settle.
    do @(negedge clk);
    while (word_queue.size() > 0 || start || results_due.size() > 0 || busy !== 1'b0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
